/* src/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with asynchronous active-low reset disable
`define TAP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("text address parser check failed");

// clocked assertion that also holds during reset
`define TAP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("text address parser check failed");

`endif

/* src/tap_pkg.sv */
// shared types and constants for the text address parser
`default_nettype none

package tap_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned AddrW = 64;
  localparam int unsigned DigitW = 4;
  localparam int unsigned CountW = 2;

  localparam logic [CountW-1:0] CountMax = 2'd3;
  localparam logic [DigitW-1:0] LetterBias = 4'd9;

  typedef struct packed {
    logic              blank;
    logic              dec_digit;
    logic              hex_letter;
    logic              x_char;
    logic              zero;
    logic [DigitW-1:0] digit;
  } char_class_t;

endpackage

`default_nettype wire

/* src/tap_char_class.sv */
// character classifier: whitespace, digits, hex letters and prefix x
`default_nettype none

module tap_char_class (
  input  wire logic [tap_pkg::CharW-1:0] char_code_i,
  output tap_pkg::char_class_t           class_o
);

  logic lower_hex;
  logic upper_hex;

  assign lower_hex = (char_code_i >= 8'h61) && (char_code_i <= 8'h66);
  assign upper_hex = (char_code_i >= 8'h41) && (char_code_i <= 8'h46);

  always_comb begin
    class_o.blank      = (char_code_i == 8'h20) ||
                         ((char_code_i >= 8'h09) && (char_code_i <= 8'h0d));
    class_o.dec_digit  = (char_code_i >= 8'h30) && (char_code_i <= 8'h39);
    class_o.hex_letter = lower_hex || upper_hex;
    class_o.x_char     = (char_code_i == 8'h78) || (char_code_i == 8'h58);
    class_o.zero       = (char_code_i == 8'h30);
    if (class_o.hex_letter) begin
      class_o.digit = {1'b0, char_code_i[2:0]} + tap_pkg::LetterBias;
    end else begin
      class_o.digit = char_code_i[3:0];
    end
  end

endmodule

`default_nettype wire

/* src/text_address_parser.sv */
// top level of the streaming ascii hex/decimal address parser
`default_nettype none

// Takes one character per cycle and keeps decimal and hexadecimal
// accumulators side by side, so a request of any length streams through at
// one character per clock with no gaps between texts. The character that
// carries end_of_text loads one result into the output register at the edge
// that accepts it; all other characters produce none. The input stalls only
// while that output register holds a result that the downstream side is
// stalling, so the sustained rate is one character per cycle, set by the
// single pass from parser state to the result register.
module text_address_parser (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire logic [tap_pkg::CharW-1:0]    char_code_i,
  input  wire logic                         end_of_text_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      logic [tap_pkg::AddrW-1:0]    word_address_o,
  output      logic                         parse_ok_o
);

  tap_pkg::char_class_t cls;

  logic [tap_pkg::AddrW-1:0]  dec_acc_q, dec_acc_d;
  logic [tap_pkg::AddrW-1:0]  hex_acc_q, hex_acc_d;
  logic [tap_pkg::CountW-1:0] cnt_q, cnt_d;
  logic                       first_zero_q, first_zero_d;
  logic                       hex_prefix_q, hex_prefix_d;
  logic                       hex_letter_q, hex_letter_d;
  logic                       space_after_q, space_after_d;
  logic                       invalid_q, invalid_d;

  logic                       out_valid_q;
  logic [tap_pkg::AddrW-1:0]  word_address_q, word_address_d;
  logic                       parse_ok_q, parse_ok_d;

  logic                       in_accept;
  logic [tap_pkg::AddrW-1:0]  digit_ext;
  logic [tap_pkg::AddrW-1:0]  value;

  tap_char_class u_char_class (
    .char_code_i (char_code_i),
    .class_o     (cls)
  );

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign digit_ext  = {{(tap_pkg::AddrW-tap_pkg::DigitW){1'b0}}, cls.digit};

  // next parser state for the current character
  always_comb begin
    dec_acc_d     = dec_acc_q;
    hex_acc_d     = hex_acc_q;
    cnt_d         = cnt_q;
    first_zero_d  = first_zero_q;
    hex_prefix_d  = hex_prefix_q;
    hex_letter_d  = hex_letter_q;
    space_after_d = space_after_q;
    invalid_d     = invalid_q;
    if (cls.blank) begin
      if (cnt_q != '0) begin
        space_after_d = 1'b1;
      end
    end else begin
      if (space_after_q) begin
        invalid_d = 1'b1;
      end
      if (cls.dec_digit) begin
        dec_acc_d = (dec_acc_q << 3) + (dec_acc_q << 1) + digit_ext;
        hex_acc_d = (hex_acc_q << 4) + digit_ext;
        if ((cnt_q == '0) && cls.zero) begin
          first_zero_d = 1'b1;
        end
      end else if (cls.hex_letter) begin
        hex_acc_d    = (hex_acc_q << 4) + digit_ext;
        hex_letter_d = 1'b1;
      end else if (cls.x_char && (cnt_q == 2'd1) && first_zero_q) begin
        hex_prefix_d = 1'b1;
        hex_acc_d    = '0;
      end else begin
        invalid_d = 1'b1;
      end
      if (cnt_q != tap_pkg::CountMax) begin
        cnt_d = cnt_q + 2'd1;
      end
    end
  end

  // result for a final character
  always_comb begin
    parse_ok_d = (cnt_d != '0) && !invalid_d &&
                 !(hex_prefix_d && (cnt_d != tap_pkg::CountMax));
    value      = (hex_prefix_d || hex_letter_d) ? hex_acc_d : dec_acc_d;
    if (parse_ok_d) begin
      word_address_d = {value[tap_pkg::AddrW-1:2], 2'b00};
    end else begin
      word_address_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_acc_q     <= '0;
      hex_acc_q     <= '0;
      cnt_q         <= '0;
      first_zero_q  <= 1'b0;
      hex_prefix_q  <= 1'b0;
      hex_letter_q  <= 1'b0;
      space_after_q <= 1'b0;
      invalid_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_accept) begin
        if (end_of_text_i) begin
          dec_acc_q     <= '0;
          hex_acc_q     <= '0;
          cnt_q         <= '0;
          first_zero_q  <= 1'b0;
          hex_prefix_q  <= 1'b0;
          hex_letter_q  <= 1'b0;
          space_after_q <= 1'b0;
          invalid_q     <= 1'b0;
        end else begin
          dec_acc_q     <= dec_acc_d;
          hex_acc_q     <= hex_acc_d;
          cnt_q         <= cnt_d;
          first_zero_q  <= first_zero_d;
          hex_prefix_q  <= hex_prefix_d;
          hex_letter_q  <= hex_letter_d;
          space_after_q <= space_after_d;
          invalid_q     <= invalid_d;
        end
      end
      if (in_accept && end_of_text_i) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && end_of_text_i) begin
      word_address_q <= word_address_d;
      parse_ok_q     <= parse_ok_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign word_address_o = word_address_q;
  assign parse_ok_o     = parse_ok_q;

endmodule

`default_nettype wire

/* src/tap_checker.sv */
// port-level checks for the text address parser and their bind
`default_nettype none

`include "assert_macros.svh"

module tap_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_stall_o,
  input wire logic                      end_of_text_i,
  input wire logic                      out_valid_o,
  input wire logic                      out_stall_i,
  input wire logic [tap_pkg::AddrW-1:0] word_address_o,
  input wire logic                      parse_ok_o
);

  logic in_last;

  assign in_last = in_valid_i && !in_stall_o && end_of_text_i;

  `TAP_ASSERT(a_result_holds, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o)
  `TAP_ASSERT(a_last_gives_result, clk_i, rst_ni, in_last |=> out_valid_o)
  `TAP_ASSERT(a_no_extra_result, clk_i, rst_ni,
    !out_valid_o && !in_last |=> !out_valid_o)
  `TAP_ASSERT(a_invalid_is_zero, clk_i, rst_ni,
    out_valid_o && !parse_ok_o |-> word_address_o == '0)
  `TAP_ASSERT(a_word_aligned, clk_i, rst_ni,
    out_valid_o |-> word_address_o[1:0] == 2'b00)

endmodule

bind text_address_parser tap_checker u_tap_checker (.*);

`default_nettype wire
